// ===== hdl/lrcm_pkg.sv =====
// Package: shared types, cause codes and disparity scaling for the consistency mask block.
package lrcm_pkg;

    localparam int unsigned COL_W  = 10;
    localparam int unsigned DISP_W = 8;
    localparam int unsigned LVL_W  = 9;
    localparam int unsigned PROD_W = DISP_W + LVL_W;

    localparam logic [LVL_W-1:0] LEVELS_RESET = LVL_W'(64);

    localparam logic [1:0] CAUSE_OK       = 2'd0;
    localparam logic [1:0] CAUSE_EDGE     = 2'd1;
    localparam logic [1:0] CAUSE_MISMATCH = 2'd2;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic        REG_LEVELS = 1'b0;

    typedef struct packed {
        logic             keep;
        logic [1:0]       cause;
        logic [DISP_W-1:0] scaled_left;
    } t_out_item;

    // raw * levels / 256, truncated, saturated at 255
    function automatic logic [DISP_W-1:0] f_scale(
        input logic [DISP_W-1:0] raw,
        input logic [LVL_W-1:0]  levels
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(levels);
        return prod[PROD_W-1] ? {DISP_W{1'b1}} : prod[PROD_W-2:DISP_W];
    endfunction

endpackage

// ===== hdl/lrcm_ifs.sv =====
// Interfaces: pixel input channel and mask result channel.
interface lrcm_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] column;
    logic [7:0] left_disparity;
    logic [7:0] right_disparity;

    modport source(output valid, column, left_disparity, right_disparity, input ready);
    modport sink(input valid, column, left_disparity, right_disparity, output ready);
endinterface

interface lrcm_out_if;
    logic       valid;
    logic       ready;
    logic       keep;
    logic [1:0] cause;
    logic [7:0] scaled_left;

    modport source(output valid, keep, cause, scaled_left, input ready);
    modport sink(input valid, keep, cause, scaled_left, output ready);
endinterface

// ===== hdl/left_right_consistency_mask.sv =====
// Top level: left/right disparity consistency check over a streamed image row.
//
//  channel  dir  handshake        payload
//  i_in     in   valid/ready      column, left_disparity, right_disparity
//  o_out    out  valid/ready      keep, cause, scaled_left
//  apb      in   psel/penable     paddr 0: disparity_levels (9 bits, reset 64)
//
//  One pixel per clock sustained while o_out keeps taking results (no backpressure).
//  Rate is set by the row store: one write and one read per cycle on its two ports.
//  Stage 1 scales both disparities, stage 2 holds the store read, then an output
//  register with a skid entry; i_in.ready drops only while the skid entry is full.
//  Synchronous active-low reset clears the pipeline valids; store contents persist.
module left_right_consistency_mask #(
    parameter int unsigned ROW_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lrcm_in_if.sink                     i_in,
    lrcm_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrcm_pkg::APB_AW-1:0] paddr,
    input  logic [lrcm_pkg::APB_DW-1:0] pwdata,
    output logic [lrcm_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import lrcm_pkg::*;

    localparam int unsigned AW = $clog2(ROW_WIDTH);
    localparam int unsigned XW = (AW > COL_W) ? AW : COL_W;

    logic [LVL_W-1:0]  w_levels;
    logic              w_en;

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [DISP_W-1:0] r_s1_dl;
    logic [DISP_W-1:0] r_s1_dr;

    logic              w_s1_edge;
    logic [COL_W-1:0]  w_s1_raddr;
    logic [XW-1:0]     w_s1_raddr_x;
    logic [XW-1:0]     w_s1_col_x;
    logic              w_s1_rd_oob;
    logic              w_s1_wr_ok;
    logic              w_we;

    logic              r_s2_valid;
    logic [DISP_W-1:0] r_s2_dl;
    logic [DISP_W-1:0] r_s2_dr;
    logic              r_s2_edge;
    logic              r_s2_now;
    logic              r_s2_oob;
    logic [DISP_W-1:0] w_rdata;
    logic [DISP_W-1:0] w_s2_dr_sel;
    t_out_item         w_s2_res;

    lrcm_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_levels (w_levels)
    );

    assign i_in.ready = w_en;

    // stage 1: scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_col <= i_in.column;
            r_s1_dl  <= f_scale(i_in.left_disparity, w_levels);
            r_s1_dr  <= f_scale(i_in.right_disparity, w_levels);
        end
    end

    assign w_s1_edge    = r_s1_col < COL_W'(r_s1_dl);
    assign w_s1_raddr   = r_s1_col - COL_W'(r_s1_dl);
    assign w_s1_raddr_x = XW'(w_s1_raddr);
    assign w_s1_col_x   = XW'(r_s1_col);
    assign w_s1_rd_oob  = 32'(w_s1_raddr) >= ROW_WIDTH;
    assign w_s1_wr_ok   = 32'(r_s1_col) < ROW_WIDTH;
    assign w_we         = w_en && r_s1_valid && w_s1_wr_ok;

    // row store: write at column, read at column - disparity in the same cycle
    lrcm_ram #(
        .WIDTH (DISP_W),
        .DEPTH (ROW_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s1_col_x[AW-1:0]),
        .i_wdata (r_s1_dr),
        .i_re    (w_en),
        .i_raddr (w_s1_raddr_x[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // stage 2: compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_dl   <= r_s1_dl;
            r_s2_dr   <= r_s1_dr;
            r_s2_edge <= w_s1_edge;
            r_s2_now  <= (r_s1_dl == '0);
            r_s2_oob  <= w_s1_rd_oob;
        end
    end

    always_comb begin
        priority if (r_s2_now) begin
            w_s2_dr_sel = r_s2_dr;
        end else if (r_s2_oob) begin
            w_s2_dr_sel = '0;
        end else begin
            w_s2_dr_sel = w_rdata;
        end

        w_s2_res.scaled_left = r_s2_dl;
        priority if (r_s2_edge) begin
            w_s2_res.keep  = 1'b0;
            w_s2_res.cause = CAUSE_EDGE;
        end else if (w_s2_dr_sel == r_s2_dl) begin
            w_s2_res.keep  = 1'b1;
            w_s2_res.cause = CAUSE_OK;
        end else begin
            w_s2_res.keep  = 1'b0;
            w_s2_res.cause = CAUSE_MISMATCH;
        end
    end

    lrcm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_data  (w_s2_res),
        .o_en    (w_en),
        .o_out   (o_out)
    );

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_s1_dl != '0) |-> (w_s1_col_x[AW-1:0] != w_s1_raddr_x[AW-1:0]))
        else $error("row store read and write hit the same entry");

    a_keep_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.keep == (o_out.cause == CAUSE_OK)))
        else $error("keep disagrees with cause");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s2_valid) && $stable(r_s1_valid)))
        else $error("pipeline moved while stalled");

endmodule

// ===== hdl/lrcm_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module lrcm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lrcm_cfg.sv =====
// APB register block holding the disparity level count.
module lrcm_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrcm_pkg::APB_AW-1:0] paddr,
    input  logic [lrcm_pkg::APB_DW-1:0] pwdata,
    output logic [lrcm_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [lrcm_pkg::LVL_W-1:0]  o_levels
);
    import lrcm_pkg::*;

    logic             w_hit;
    logic [LVL_W-1:0] r_levels;

    assign w_hit = (paddr[APB_AW-1] == REG_LEVELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_levels <= pwdata[LVL_W-1:0];
        end
    end

    assign prdata   = w_hit ? APB_DW'(r_levels) : '0;
    assign pready   = 1'b1;
    assign o_levels = r_levels;

endmodule

// ===== hdl/lrcm_skid.sv =====
// Output register with skid entry; decouples result backpressure from the pipeline.
module lrcm_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lrcm_pkg::t_out_item i_data,
    output logic                o_en,
    lrcm_out_if.source          o_out
);
    import lrcm_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      w_take;

    assign w_take = r_out_valid && o_out.ready;
    assign o_en   = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.keep        = r_out.keep;
    assign o_out.cause       = r_out.cause;
    assign o_out.scaled_left = r_out.scaled_left;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_take) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");

endmodule

// ===== tb/left_right_consistency_mask_checker.sv =====
// Checker: follows the pixel and mask channels, predicts every mask result and compares it.
module left_right_consistency_mask_checker #(
    parameter int unsigned ROW_W = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lrcm_in_if                          i_pix,
    lrcm_out_if                         i_mask,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrcm_pkg::APB_AW-1:0] paddr,
    input  logic [lrcm_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          o_pending,
    output int                          o_fails,
    output int                          o_n_ok,
    output int                          o_n_edge,
    output int                          o_n_mismatch
);
    timeunit 1ns;
    timeprecision 1ps;

    import lrcm_pkg::*;

    localparam logic [APB_AW-1:0] LEVELS_ADDR = APB_AW'(4 * REG_LEVELS);

    logic [LVL_W-1:0]  levels = LEVELS_RESET;
    logic [DISP_W-1:0] right_disp_row [ROW_W];
    t_out_item         mask_q [$];
    int                fails     = 0;
    int                n_ok      = 0;
    int                n_edge    = 0;
    int                n_mis     = 0;

    function automatic logic [DISP_W-1:0] scale_disp(input logic [DISP_W-1:0] raw);
        logic [DISP_W+LVL_W-1:0] prod;
        prod = {{LVL_W{1'b0}}, raw} * {{DISP_W{1'b0}}, levels};
        return (prod[DISP_W+LVL_W-1:DISP_W] > 255) ? {DISP_W{1'b1}}
                                                    : prod[2*DISP_W-1:DISP_W];
    endfunction

    // store the scaled right value first, then look back by the left disparity for a match
    function automatic t_out_item mask_pixel(input logic [COL_W-1:0]  col,
                                             input logic [DISP_W-1:0] left_raw,
                                             input logic [DISP_W-1:0] right_raw);
        logic [DISP_W-1:0] dl;
        logic [DISP_W-1:0] dr_now;
        logic [DISP_W-1:0] dr_seen;
        int unsigned       addr;
        t_out_item         res;
        dl     = scale_disp(left_raw);
        dr_now = scale_disp(right_raw);
        if (col < ROW_W) begin
            right_disp_row[col] = dr_now;
        end
        res.scaled_left = dl;
        if (col < dl) begin
            res.keep  = 1'b0;
            res.cause = CAUSE_EDGE;
        end else begin
            addr = col - dl;
            if (dl == '0) begin
                dr_seen = dr_now;
            end else if (addr < ROW_W) begin
                dr_seen = right_disp_row[addr];
            end else begin
                dr_seen = '0;
            end
            res.keep  = (dr_seen == dl);
            res.cause = res.keep ? CAUSE_OK : CAUSE_MISMATCH;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            mask_q.delete();
            levels = LEVELS_RESET;
            foreach (right_disp_row[k]) right_disp_row[k] = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == LEVELS_ADDR) begin
                levels = pwdata[LVL_W-1:0];
            end
            if (i_mask.valid && i_mask.ready) begin
                if (mask_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected mask transaction: keep=%0d cause=%0d %s%0d",
                             $time, i_mask.keep, i_mask.cause, "scaled_left=",
                             i_mask.scaled_left);
                end else begin
                    want = mask_q.pop_front();
                    if (want.keep !== i_mask.keep || want.cause !== i_mask.cause
                            || want.scaled_left !== i_mask.scaled_left) begin
                        fails++;
                        $display("%0t: mask mismatch: expected keep=%0d cause=%0d %s%0d,",
                                 $time, want.keep, want.cause, "scaled_left=",
                                 want.scaled_left);
                        $display("    got keep=%0d cause=%0d scaled_left=%0d",
                                 i_mask.keep, i_mask.cause, i_mask.scaled_left);
                    end
                    case (want.cause)
                        CAUSE_OK:       n_ok++;
                        CAUSE_EDGE:     n_edge++;
                        CAUSE_MISMATCH: n_mis++;
                        default: ;
                    endcase
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                mask_q.push_back(mask_pixel(i_pix.column, i_pix.left_disparity,
                                            i_pix.right_disparity));
            end
        end
        o_pending    <= mask_q.size();
        o_fails      <= fails;
        o_n_ok       <= n_ok;
        o_n_edge     <= n_edge;
        o_n_mismatch <= n_mis;
    end

endmodule

// ===== tb/left_right_consistency_mask_tb.sv =====
// Testbench top: clock, reset, register writes, pixel stimulus and verdict.
module left_right_consistency_mask_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrcm_pkg::*;

    localparam int unsigned       ROW_W          = 1024;
    localparam int unsigned       ITEMS_PER_PASS = 200;
    localparam int unsigned       WATCHDOG_LIMIT = 2000;
    localparam logic [APB_AW-1:0] LEVELS_ADDR    = APB_AW'(4 * REG_LEVELS);

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                pending;
    int                fails;
    int                n_ok;
    int                n_edge;
    int                n_mismatch;

    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct     = 0;
    int unsigned       idle_cycles   = 0;
    int unsigned       n_sent        = 0;
    int unsigned       n_settings    = 1;
    logic [LVL_W-1:0]  cur_levels    = LEVELS_RESET;
    bit                col_written [ROW_W];
    int unsigned       next_col      = 0;
    int unsigned       seg_left      = 0;
    logic [DISP_W-1:0] seg_raw       = '0;

    lrcm_in_if  pix_ch();
    lrcm_out_if mask_ch();

    left_right_consistency_mask #(
        .ROW_WIDTH (ROW_W)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (pix_ch),
        .o_out   (mask_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    left_right_consistency_mask_checker #(
        .ROW_W (ROW_W)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_ch),
        .i_mask       (mask_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_pending    (pending),
        .o_fails      (fails),
        .o_n_ok       (n_ok),
        .o_n_edge     (n_edge),
        .o_n_mismatch (n_mismatch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        mask_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (mask_ch.valid && mask_ch.ready)
                || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [COL_W-1:0]  col,
                              input logic [DISP_W-1:0] left_raw,
                              input logic [DISP_W-1:0] right_raw);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid           <= 1'b1;
        pix_ch.column          <= col;
        pix_ch.left_disparity  <= left_raw;
        pix_ch.right_disparity <= right_raw;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        col_written[col] = 1'b1;
        n_sent++;
    endtask

    // hold the pixel stream until every outstanding mask transaction has come back
    task automatic drain();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_levels(input logic [LVL_W-1:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= LEVELS_ADDR;
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        cur_levels = value;
        n_settings++;
    endtask

    // rows of flat disparity segments, so that most left pixels find a matching right
    // pixel; occlusions, skipped columns, row restarts and some pure noise mixed in
    task automatic random_pixel();
        logic [COL_W-1:0]  col;
        logic [DISP_W-1:0] lraw;
        logic [DISP_W-1:0] rraw;
        int unsigned       roll;
        int unsigned       dl;
        int unsigned       tries;
        roll = $urandom_range(99);
        if (roll < 5) begin
            col  = COL_W'($urandom);
            lraw = DISP_W'($urandom);
            rraw = DISP_W'($urandom);
        end else begin
            if (next_col >= ROW_W || roll < 7) begin
                next_col = 0;
            end
            if (seg_left == 0 || $urandom_range(19) == 0) begin
                seg_raw  = DISP_W'($urandom);
                seg_left = $urandom_range(8, 60);
            end
            col  = COL_W'(next_col);
            lraw = seg_raw;
            rraw = seg_raw;
            if ($urandom_range(9) == 0) rraw = DISP_W'($urandom);
            if ($urandom_range(9) == 0) lraw = DISP_W'($urandom);
            seg_left--;
            next_col += ($urandom_range(9) < 6) ? 1 : $urandom_range(2, 16);
        end
        // never look back at a column that has not been written since reset
        tries = 0;
        forever begin
            dl = (lraw * cur_levels) >> 8;
            if (dl > 255) dl = 255;
            if (dl == 0 || col < dl || col_written[col - dl]) break;
            lraw = (tries < 4) ? DISP_W'($urandom) : '0;
            tries++;
        end
        send_pixel(col, lraw, rraw);
    endtask

    initial begin : stimulus
        int unsigned      pause_at;
        logic [LVL_W-1:0] lvl;
        pix_ch.valid           = 1'b0;
        pix_ch.column          = '0;
        pix_ch.left_disparity  = '0;
        pix_ch.right_disparity = '0;
        mask_ch.ready          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset levels: zero-disparity forwarding, left edge, hits and misses in the store
        send_pixel(10'd0, 8'd0, 8'd0);
        send_pixel(10'd1, 8'd255, 8'd255);
        send_pixel(10'd2, 8'd0, 8'd4);
        send_pixel(10'd3, 8'd4, 8'd0);
        send_pixel(10'd4, 8'd8, 8'd0);
        send_pixel(10'd1023, 8'd0, 8'd255);
        send_pixel(10'd1023, 8'd0, 8'd0);
        send_pixel(10'd0, 8'd255, 8'd0);
        send_pixel(10'd5, 8'd4, 8'd0);
        drain();
        write_levels(9'd256);
        send_pixel(10'd6, 8'd255, 8'd255);
        send_pixel(10'd255, 8'd255, 8'd0);
        send_pixel(10'd7, 8'd1, 8'd170);
        send_pixel(10'd8, 8'd2, 8'd0);
        send_pixel(10'd16, 8'd0, 8'd10);
        send_pixel(10'd26, 8'd10, 8'd0);
        drain();
        // at 511 levels the larger raw values saturate at 255
        write_levels(9'd511);
        send_pixel(10'd9, 8'd255, 8'd255);
        send_pixel(10'd10, 8'd1, 8'd1);
        send_pixel(10'd11, 8'd0, 8'd128);
        send_pixel(10'd12, 8'd1, 8'd0);
        drain();
        write_levels(9'd0);
        send_pixel(10'd13, 8'd255, 8'd255);
        send_pixel(10'd1023, 8'd255, 8'd85);
        drain();
        write_levels(9'd1);
        send_pixel(10'd14, 8'd255, 8'd255);
        send_pixel(10'd15, 8'd128, 8'd7);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: lvl = 9'd64;
                1: lvl = 9'd256;
                2: lvl = 9'd1;
                3: lvl = 9'd511;
                4: lvl = 9'd0;
                5: lvl = 9'd300;
                6: lvl = LVL_W'($urandom_range(1, 256));
                default: lvl = LVL_W'($urandom_range(0, 511));
            endcase
            drain();
            write_levels(lvl);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            pause_at = $urandom_range(20, ITEMS_PER_PASS - 20);
            for (int i = 0; i < ITEMS_PER_PASS; i++) begin
                if (i == pause_at) drain();
                random_pixel();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d pixels under %0d disparity-level settings,", n_sent, n_settings);
        $display("idle and stall mixes included: %0d consistent, %0d off the left edge, %0d %s",
                 n_ok, n_edge, n_mismatch, "mismatched.");
        if (fails == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lrcm_pkg.sv
hdl/lrcm_ifs.sv
hdl/lrcm_ram.sv
hdl/lrcm_cfg.sv
hdl/lrcm_skid.sv
hdl/left_right_consistency_mask.sv
tb/left_right_consistency_mask_checker.sv
tb/left_right_consistency_mask_tb.sv
